[rtl/grid_dfs_explorer_step_defines.svh]
// Assertion macros used by the explorer top level.
// Define ASSERT_OFF to compile the checks out.
`ifndef GRID_DFS_EXPLORER_STEP_DEFINES_SVH
`define GRID_DFS_EXPLORER_STEP_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset
`define GDFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition that must never hold outside reset
`define GDFS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define GDFS_ASSERT(lbl, prop, msg)
`define GDFS_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/gdfs_pkg.sv]
package gdfs_pkg;

    // Grid size
    localparam int GRID_ROWS = 4;
    localparam int GRID_COLS = 5;
    localparam int CELLS     = GRID_ROWS * GRID_COLS;

    // Field widths fixed by the interface
    localparam int ROW_W  = 2;
    localparam int COL_W  = 3;
    localparam int HEAD_W = 2;
    localparam int CMD_W  = 2;
    localparam int MOVE_W = 3;
    localparam int ST_W   = 2;

    // Storage sizing
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SP_W   = $clog2(CELLS + 1);

    // Port widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP    = 2'd2;

    // Cell status codes
    localparam logic [ST_W-1:0] ST_UNVISITED = 2'd0;
    localparam logic [ST_W-1:0] ST_VISITED   = 2'd1;
    localparam logic [ST_W-1:0] ST_OBSTACLE  = 2'd2;

    // Absolute directions
    localparam logic [HEAD_W-1:0] DIR_N = 2'd0;
    localparam logic [HEAD_W-1:0] DIR_E = 2'd1;
    localparam logic [HEAD_W-1:0] DIR_S = 2'd2;
    localparam logic [HEAD_W-1:0] DIR_W = 2'd3;
    localparam logic [HEAD_W-1:0] REL_LAST = 2'd3;

    // Move codes
    localparam logic [MOVE_W-1:0] MOVE_FWD  = 3'd0;
    localparam logic [MOVE_W-1:0] MOVE_DONE = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd2;

    typedef logic [ST_W-1:0] t_status;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cell;

    // Input beat, last field in the low bits
    typedef struct packed {
        logic [COL_W-1:0] cell_col;
        logic [ROW_W-1:0] cell_row;
        logic [CMD_W-1:0] command;
    } t_item;

    // Result beat, last field in the low bits
    typedef struct packed {
        logic [HEAD_W-1:0] new_heading;
        logic [COL_W-1:0]  new_col;
        logic [ROW_W-1:0]  new_row;
        logic [MOVE_W-1:0] move;
    } t_result;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [HEAD_W-1:0] heading;
    } t_start;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_status           wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_map_req;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_cell             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_stk_req;

    typedef struct packed {
        logic             ok;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_nbr;

    // Linear cell address, row major
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * GRID_COLS + int'(col));
    endfunction

    // Neighbour in an absolute direction; ok is low when it lies off the grid
    function automatic t_nbr nbr_of(input logic [ROW_W-1:0]  row,
                                    input logic [COL_W-1:0]  col,
                                    input logic [HEAD_W-1:0] dir);
        t_nbr n;
        n.ok  = 1'b1;
        n.row = row;
        n.col = col;
        unique case (dir)
            DIR_N: begin
                n.ok  = (row != '0);
                n.row = row - 1'b1;
            end
            DIR_E: begin
                n.ok  = (int'(col) + 1 < GRID_COLS);
                n.col = col + 1'b1;
            end
            DIR_S: begin
                n.ok  = (int'(row) + 1 < GRID_ROWS);
                n.row = row + 1'b1;
            end
            default: begin
                n.ok  = (col != '0);
                n.col = col - 1'b1;
            end
        endcase
        return n;
    endfunction

    function automatic logic [ROW_W-1:0] sat_row(input logic [ROW_W-1:0] row);
        return (int'(row) < GRID_ROWS) ? row : ROW_W'(GRID_ROWS - 1);
    endfunction

    function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] col);
        return (int'(col) < GRID_COLS) ? col : COL_W'(GRID_COLS - 1);
    endfunction

endpackage

[rtl/gdfs_ram.sv]
module gdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port (old data on a collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/gdfs_ctrl.sv]
module gdfs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gdfs_pkg::t_item    i_item,
    input  gdfs_pkg::t_start   i_start,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output gdfs_pkg::t_result  o_res,
    output gdfs_pkg::t_map_req o_map_req,
    input  gdfs_pkg::t_status  i_map_rdata,
    output gdfs_pkg::t_stk_req o_stk_req,
    input  gdfs_pkg::t_cell    i_stk_rdata
);
    import gdfs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_VISIT  = 7'b0000010,
        S_READ   = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_NOMOVE = 7'b0010000,
        S_BACK   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row,   n_row;
    logic [COL_W-1:0]   r_col,   n_col;
    logic [HEAD_W-1:0]  r_head,  n_head;
    logic [SP_W-1:0]    r_sp,    n_sp;
    logic [HEAD_W-1:0]  r_rel,   n_rel;
    logic [MOVE_W-1:0]  r_move,  n_move;
    logic [CELLS-1:0]   r_vld,   n_vld;
    logic               r_nb_vld, n_nb_vld;

    logic [HEAD_W-1:0]  w_dir;
    t_nbr               w_nb;
    logic [ADDR_W-1:0]  w_nb_addr;
    logic [ADDR_W-1:0]  w_cur_addr;
    logic [ADDR_W-1:0]  w_mark_addr;
    logic               w_mark_ok;
    logic               w_open;
    logic               w_found;
    logic [HEAD_W-1:0]  w_found_dir;
    logic [SP_W-1:0]    w_sp_dec;
    t_nbr               w_back_nb;

    // Probe direction and the neighbour it points at
    assign w_dir       = r_head + r_rel;
    assign w_nb        = nbr_of(r_row, r_col, w_dir);
    assign w_nb_addr   = cell_addr(w_nb.row, w_nb.col);
    assign w_cur_addr  = cell_addr(r_row, r_col);
    assign w_mark_addr = cell_addr(i_item.cell_row, i_item.cell_col);
    assign w_mark_ok   = (int'(i_item.cell_row) < GRID_ROWS) &&
                         (int'(i_item.cell_col) < GRID_COLS);
    assign w_open      = !r_nb_vld || (i_map_rdata == ST_UNVISITED);
    assign w_sp_dec    = r_sp - 1'b1;

    // Which way the popped cell lies; the lowest matching direction wins
    always_comb begin
        w_found     = 1'b0;
        w_found_dir = DIR_N;
        w_back_nb   = '0;
        for (int d = 3; d >= 0; d--) begin
            w_back_nb = nbr_of(r_row, r_col, HEAD_W'(d));
            if (w_back_nb.ok && w_back_nb.row == i_stk_rdata.row &&
                w_back_nb.col == i_stk_rdata.col) begin
                w_found     = 1'b1;
                w_found_dir = HEAD_W'(d);
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = '{new_heading: r_head, new_col: r_col,
                           new_row: r_row, move: r_move};

    // Sequencer: restart or mark in idle; a step visits, probes up to four neighbours, pushes or pops, emits
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_head   = r_head;
        n_sp     = r_sp;
        n_rel    = r_rel;
        n_move   = r_move;
        n_vld    = r_vld;
        n_nb_vld = r_nb_vld;

        o_map_req       = '0;
        o_map_req.waddr = w_cur_addr;
        o_map_req.raddr = w_nb_addr;
        o_stk_req       = '0;
        o_stk_req.waddr = r_sp[ADDR_W-1:0];
        o_stk_req.wdata = '{row: r_row, col: r_col};
        o_stk_req.raddr = w_sp_dec[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_item.command == CMD_RESTART) begin
                        n_vld  = '0;
                        n_sp   = '0;
                        n_row  = sat_row(i_start.row);
                        n_col  = sat_col(i_start.col);
                        n_head = i_start.heading;
                    end else if (i_item.command == CMD_MARK) begin
                        if (w_mark_ok) begin
                            o_map_req.we    = 1'b1;
                            o_map_req.waddr = w_mark_addr;
                            o_map_req.wdata = ST_OBSTACLE;
                            n_vld[w_mark_addr] = 1'b1;
                        end
                    end else if (i_item.command == CMD_STEP) begin
                        n_state = S_VISIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_VISIT: begin
                o_map_req.we      = 1'b1;
                o_map_req.wdata   = ST_VISITED;
                n_vld[w_cur_addr] = 1'b1;
                n_rel             = '0;
                n_state           = S_READ;
            end
            S_READ: begin
                if (w_nb.ok) begin
                    o_map_req.re = 1'b1;
                    n_nb_vld     = r_vld[w_nb_addr];
                    n_state      = S_CHECK;
                end else if (r_rel == REL_LAST) begin
                    n_state = S_NOMOVE;
                end else begin
                    n_rel = r_rel + 1'b1;
                end
            end
            S_CHECK: begin
                if (w_open) begin
                    if (int'(r_sp) < CELLS) begin
                        o_stk_req.we = 1'b1;
                        n_sp         = r_sp + 1'b1;
                    end
                    n_row   = w_nb.row;
                    n_col   = w_nb.col;
                    n_head  = w_dir;
                    n_move  = {1'b0, r_rel};
                    n_state = S_EMIT;
                end else if (r_rel == REL_LAST) begin
                    n_state = S_NOMOVE;
                end else begin
                    n_rel   = r_rel + 1'b1;
                    n_state = S_READ;
                end
            end
            S_NOMOVE: begin
                if (r_sp != '0) begin
                    o_stk_req.re = 1'b1;
                    n_sp         = w_sp_dec;
                    n_state      = S_BACK;
                end else begin
                    n_move  = MOVE_DONE;
                    n_state = S_EMIT;
                end
            end
            S_BACK: begin
                if (w_found) begin
                    n_move = {1'b0, w_found_dir - r_head};
                    n_head = w_found_dir;
                end else begin
                    n_move = MOVE_FWD;
                end
                n_row   = i_stk_rdata.row;
                n_col   = i_stk_rdata.col;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_head  <= DIR_N;
            r_sp    <= '0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_head  <= n_head;
            r_sp    <= n_sp;
            r_vld   <= n_vld;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_rel    <= n_rel;
        r_move   <= n_move;
        r_nb_vld <= n_nb_vld;
    end

endmodule

[rtl/grid_dfs_explorer_step.sv]
// Channel    Direction  Beat contents
// s_axis     in         tdata: command[1:0], cell_row[3:2], cell_col[6:4]
// m_axis     out        tdata: move[2:0], new_row[4:3], new_col[7:5], new_heading[9:8]
// i_cfg      in         index 0 origin row, 1 origin column, 2 origin heading
//
// Restart, mark and unknown commands are handled in the idle state as the beat is taken.
// A step takes the beat, writes the visited mark, probes neighbours through the
// single read port of the map RAM, pops from the stack RAM at a dead end, and
// hands the result on.
// Reset is synchronous, active low, and clears the map at once (valid bits).
// The output register holds a result while the next beat is taken in; a step
// waits only if its result finds that register still full.
`include "grid_dfs_explorer_step_defines.svh"

module grid_dfs_explorer_step (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // command[1:0], cell_row[3:2], cell_col[6:4], zero[7]
    input  logic [gdfs_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // move[2:0], new_row[4:3], new_col[7:5], new_heading[9:8], zero[15:10]
    output logic [gdfs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gdfs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gdfs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import gdfs_pkg::*;

    localparam int OUT_PAD_W = OUT_TDATA_W - $bits(t_result);

    t_start   r_start;
    t_result  r_out;
    logic     r_out_valid;

    t_item    w_item;
    t_result  w_res;
    logic     w_res_valid;
    logic     w_res_ready;
    t_map_req w_map_req;
    t_status  w_map_rdata;
    t_stk_req w_stk_req;
    t_cell    w_stk_rdata;

    assign w_item      = s_axis_tdata[$bits(t_item)-1:0];
    assign w_res_ready = !r_out_valid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    // Start registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_ROW:  r_start.row     <= i_cfg_data[ROW_W-1:0];
                CFG_START_COL:  r_start.col     <= i_cfg_data[COL_W-1:0];
                CFG_START_HEAD: r_start.heading <= i_cfg_data[HEAD_W-1:0];
                default:        r_start         <= r_start;
            endcase
        end
    end

    gdfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_item      (w_item),
        .i_start     (r_start),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_map_req   (w_map_req),
        .i_map_rdata (w_map_rdata),
        .o_stk_req   (w_stk_req),
        .i_stk_rdata (w_stk_rdata)
    );

    // Cell status map
    gdfs_ram #(
        .WIDTH ($bits(t_status)),
        .DEPTH (CELLS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_req.we),
        .i_waddr (w_map_req.waddr),
        .i_wdata (w_map_req.wdata),
        .i_re    (w_map_req.re),
        .i_raddr (w_map_req.raddr),
        .o_rdata (w_map_rdata)
    );

    // Path stack
    gdfs_ram #(
        .WIDTH ($bits(t_cell)),
        .DEPTH (CELLS)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_req.we),
        .i_waddr (w_stk_req.waddr),
        .i_wdata (w_stk_req.wdata),
        .i_re    (w_stk_req.re),
        .i_raddr (w_stk_req.raddr),
        .o_rdata (w_stk_rdata)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {OUT_PAD_W'(0), r_out};

    // A step beat closes the input until its result enters the output register
    `GDFS_ASSERT(a_step_blocks_input,
        (s_axis_tvalid && s_axis_tready && w_item.command == CMD_STEP) |=> !s_axis_tready,
        "input still open after a step beat")
    // The sequencer never offers a result while taking a beat
    `GDFS_NEVER(a_no_result_in_idle, s_axis_tready && w_res_valid,
        "result offered while idle")
    // A map write never hits the neighbour being read in the same cycle
    `GDFS_NEVER(a_map_no_collision,
        w_map_req.we && w_map_req.re && (w_map_req.waddr == w_map_req.raddr),
        "map read and write collide")

endmodule

[sim/tb_grid_dfs_explorer_step.sv]
module tb_grid_dfs_explorer_step;

    import gdfs_pkg::*;

    localparam int SETTLE_CYCLES = 16;       // margin past the longest step
    localparam int RANDOM_ITEMS  = 700;
    localparam int TIMEOUT_UNITS = 3000000;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    // One pending input beat; a held beat waits until all results are back
    typedef struct {
        t_item item;
        bit    hold;
    } t_cmd_beat;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [IN_TDATA_W-1:0]        s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]       m_axis_tdata;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;

    // Stimulus and expectation stores
    t_cmd_beat cmd_queue[$];
    t_result   step_results[$];

    // Explorer model state
    t_status           cell_map [CELLS];
    t_cell             trail[$];
    int                pos_r;
    int                pos_c;
    logic [HEAD_W-1:0] heading;
    logic [ROW_W-1:0]  cfg_row;
    logic [COL_W-1:0]  cfg_col;
    logic [HEAD_W-1:0] cfg_head;

    // Run bookkeeping
    int  mismatches = 0;
    int  random_items = 0;
    int  steps_checked = 0;
    int  finished_seen = 0;
    int  backtracks_seen = 0;
    int  cfg_settings = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  tx_valid_nx;
    bit  rx_beat;
    t_cmd_beat tx_beat;
    t_result got;
    t_result want;

    grid_dfs_explorer_step u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap(input bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got_v, want_v);
        mismatches++;
    endtask

    // Cell next to (r, c) in an absolute direction; false when off the grid
    function automatic bit adjacent_cell(input int r, input int c, input logic [HEAD_W-1:0] dir,
                                         output int nr, output int nc);
        nr = r;
        nc = c;
        case (dir)
            DIR_N: nr = r - 1;
            DIR_E: nc = c + 1;
            DIR_S: nr = r + 1;
            default: nc = c - 1;
        endcase
        return nr >= 0 && nr < GRID_ROWS && nc >= 0 && nc < GRID_COLS;
    endfunction

    function automatic void restart_map();
        foreach (cell_map[i])
            cell_map[i] = ST_UNVISITED;
        trail.delete();
        pos_r   = (int'(cfg_row) < GRID_ROWS) ? int'(cfg_row) : GRID_ROWS - 1;
        pos_c   = (int'(cfg_col) < GRID_COLS) ? int'(cfg_col) : GRID_COLS - 1;
        heading = cfg_head;
    endfunction

    // Apply one accepted command to the explorer state; steps queue a result
    function automatic void explore_item(input t_item it);
        int                nr;
        int                nc;
        int                rel;
        bit                moved;
        logic [HEAD_W-1:0] dir;
        logic [MOVE_W-1:0] mv;
        t_cell             here;
        t_cell             prev;
        t_result           res;
        case (it.command)
            CMD_RESTART: restart_map();
            CMD_MARK: begin
                if (int'(it.cell_row) < GRID_ROWS && int'(it.cell_col) < GRID_COLS)
                    cell_map[int'(it.cell_row) * GRID_COLS + int'(it.cell_col)] = ST_OBSTACLE;
            end
            CMD_STEP: begin
                cell_map[pos_r * GRID_COLS + pos_c] = ST_VISITED;
                moved = 1'b0;
                mv    = MOVE_DONE;
                // forward, right, back, left relative to the heading
                for (rel = 0; rel < 4; rel++) begin
                    if (!moved) begin
                        dir = heading + HEAD_W'(rel);
                        if (adjacent_cell(pos_r, pos_c, dir, nr, nc) &&
                            cell_map[nr * GRID_COLS + nc] == ST_UNVISITED) begin
                            here.row = ROW_W'(pos_r);
                            here.col = COL_W'(pos_c);
                            if (trail.size() < CELLS)
                                trail.push_back(here);
                            pos_r   = nr;
                            pos_c   = nc;
                            heading = dir;
                            mv      = MOVE_W'(rel);
                            moved   = 1'b1;
                        end
                    end
                end
                // dead end: back up to the cell we came from
                if (!moved && trail.size() != 0) begin
                    prev = trail.pop_back();
                    mv   = MOVE_FWD;
                    for (rel = 3; rel >= 0; rel--) begin
                        dir = HEAD_W'(rel);
                        if (adjacent_cell(pos_r, pos_c, dir, nr, nc) &&
                            nr == int'(prev.row) && nc == int'(prev.col)) begin
                            mv      = MOVE_W'(HEAD_W'(dir - heading));
                            heading = dir;
                        end
                    end
                    pos_r = int'(prev.row);
                    pos_c = int'(prev.col);
                end
                res.move        = mv;
                res.new_row     = ROW_W'(pos_r);
                res.new_col     = COL_W'(pos_c);
                res.new_heading = heading;
                step_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Input driver: one beat per handshake, random gaps between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            tx_valid_nx = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                explore_item(t_item'(s_axis_tdata[$bits(t_item)-1:0]));
                tx_wait     = pick_gap(tx_idle_on);
                tx_valid_nx = 1'b0;
            end
            if (!tx_valid_nx) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (cmd_queue.size() != 0 &&
                             (!cmd_queue[0].hold || step_results.size() == 0)) begin
                    tx_beat = cmd_queue.pop_front();
                    s_axis_tdata <= IN_TDATA_W'(tx_beat.item);
                    tx_valid_nx = 1'b1;
                end
            end
            s_axis_tvalid <= tx_valid_nx;
        end
    end

    // Result monitor: compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            rx_beat = m_axis_tvalid && m_axis_tready;
            if (rx_beat) begin
                got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                if (m_axis_tdata[OUT_TDATA_W-1:$bits(t_result)] != '0)
                    report_mismatch("tdata padding",
                                    int'(m_axis_tdata[OUT_TDATA_W-1:$bits(t_result)]), 0);
                if (step_results.size() == 0) begin
                    report_mismatch("result beat with no step outstanding",
                                    int'(m_axis_tdata), -1);
                end else begin
                    want = step_results.pop_front();
                    steps_checked++;
                    if (want.move == MOVE_DONE)
                        finished_seen++;
                    if (got.move != want.move)
                        report_mismatch("move", got.move, want.move);
                    if (got.new_row != want.new_row)
                        report_mismatch("new_row", got.new_row, want.new_row);
                    if (got.new_col != want.new_col)
                        report_mismatch("new_col", got.new_col, want.new_col);
                    if (got.new_heading != want.new_heading)
                        report_mismatch("new_heading", got.new_heading, want.new_heading);
                end
                rx_wait = pick_gap(rx_idle_on);
            end else if (rx_wait == 0 && $urandom_range(0, 15) == 0) begin
                rx_wait = pick_gap(rx_idle_on);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input int row, input int col,
                           input bit hold = 1'b0);
        t_cmd_beat b;
        b.item.command  = cmd;
        b.item.cell_row = ROW_W'(row);
        b.item.cell_col = COL_W'(col);
        b.hold          = hold;
        cmd_queue.push_back(b);
    endtask

    task automatic add_random(input logic [CMD_W-1:0] cmd, input bit hold = 1'b0);
        add_cmd(cmd, $urandom_range(0, 3), $urandom_range(0, 7), hold);
        if (cmd != CMD_UNKNOWN)
            random_items++;
    endtask

    // Register write over the config channel, model updated on the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_START_ROW:  cfg_row  = ROW_W'(value);
            CFG_START_COL:  cfg_col  = COL_W'(value);
            CFG_START_HEAD: cfg_head = HEAD_W'(value);
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_start(input int row, input int col, input int head);
        write_reg(CFG_START_ROW, row);
        write_reg(CFG_START_COL, col);
        write_reg(CFG_START_HEAD, head);
        cfg_settings++;
        @(negedge i_clk);
    endtask

    // Block is idle: nothing queued, nothing on the bus, all results back
    task automatic wait_quiet();
        do
            @(negedge i_clk);
        while (cmd_queue.size() != 0 || s_axis_tvalid || step_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Restart, a few obstacles, then a run of steps with the odd stray command
    task automatic run_tour();
        int nsteps;
        int roll;
        add_random(CMD_RESTART);
        repeat ($urandom_range(0, 6)) add_random(CMD_MARK);
        nsteps = $urandom_range(10, 50);
        for (int i = 0; i < nsteps; i++) begin
            roll = $urandom_range(0, 39);
            if (roll == 0)
                add_random(CMD_MARK);
            else if (roll == 1)
                add_random(CMD_UNKNOWN);
            else if (roll == 2)
                add_random(CMD_RESTART);
            else
                add_random(CMD_STEP, i == 5 && $urandom_range(0, 3) == 0);
        end
    endtask

    // Fully random commands
    task automatic run_noise();
        repeat ($urandom_range(5, 15))
            add_random(CMD_W'($urandom_range(0, 3)));
    endtask

    initial begin
        int phase;
        int tours;
        cfg_row  = '0;
        cfg_col  = '0;
        cfg_head = '0;
        restart_map();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset start, stray commands, boxed-in start, short walk
        add_cmd(CMD_STEP, 0, 0);
        add_cmd(CMD_UNKNOWN, 3, 7);
        add_cmd(CMD_MARK, 3, 7);
        add_cmd(CMD_MARK, 0, 5);
        add_cmd(CMD_RESTART, 3, 7);
        add_cmd(CMD_MARK, 0, 1);
        add_cmd(CMD_MARK, 1, 0);
        add_cmd(CMD_STEP, 3, 7);
        add_cmd(CMD_STEP, 0, 0);
        add_cmd(CMD_RESTART, 0, 0);
        add_cmd(CMD_MARK, 3, 4);
        add_cmd(CMD_STEP, 0, 0);
        add_cmd(CMD_STEP, 0, 0);
        add_cmd(CMD_STEP, 0, 0, 1'b1);
        add_cmd(CMD_STEP, 0, 0);
        add_cmd(CMD_STEP, 0, 0);
        wait_quiet();

        // Directed: start column beyond the grid, heading west
        set_start(3, 7, 3);
        add_cmd(CMD_RESTART, 0, 0);
        add_cmd(CMD_MARK, 3, 3);
        repeat (5) add_cmd(CMD_STEP, 1, 2);

        // Random phases, each with its own start and idling pattern
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_quiet();
            case (phase)
                0: set_start(0, 0, 0);
                1: set_start(3, 4, 1);
                2: set_start(0, 5, 2);
                3: set_start(3, 0, 3);
                default: set_start($urandom_range(0, 3), $urandom_range(0, 7),
                                   $urandom_range(0, 3));
            endcase
            tx_idle_on = (phase % 4 != 1);
            rx_idle_on = (phase % 4 == 0 || phase % 4 == 3);
            tours = $urandom_range(2, 4);
            for (int t = 0; t < tours && random_items < RANDOM_ITEMS; t++) begin
                if ($urandom_range(0, 5) == 0)
                    run_noise();
                run_tour();
            end
            phase++;
        end
        wait_quiet();

        $display("Checked %0d step results (%0d finished) over %0d start settings;",
                 steps_checked, finished_seen, cfg_settings);
        $display("%0d random commands driven with random idling on both channels.",
                 random_items);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("Some tests failed");
        $finish;
    end

endmodule

[grid_dfs_explorer_step.f]
+incdir+rtl
rtl/gdfs_pkg.sv
rtl/gdfs_ram.sv
rtl/gdfs_ctrl.sv
rtl/grid_dfs_explorer_step.sv
sim/tb_grid_dfs_explorer_step.sv
